### rtl/core/br1_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// br1_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// byterun1 planar body decoder.
// ----------------------------------------------------------------------------
package br1_pkg;

  // image geometry
  localparam int unsigned ROW_BYTES   = 40;
  localparam int unsigned ROWS        = 200;
  localparam int unsigned MAX_PLANES  = 5;
  localparam int unsigned LANES       = 4;
  localparam int unsigned PLANE_BYTES = ROWS * ROW_BYTES;

  // register map
  localparam logic [2:0] REG_PLANE_COUNT = 3'd0;
  localparam logic [2:0] PLANE_COUNT_RST = 3'd5;

  // decoder phase
  typedef enum logic [2:0] {
    ST_CTRL,
    ST_LIT,
    ST_RUN,
    ST_SKIP,
    ST_EMIT
  } br1_state_t;

  // controller to datapath
  typedef struct packed {
    logic restart;
    logic load_ctrl;
    logic lit;
    logic run_load;
    logic skip;
    logic beat;
  } br1_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic code_is_run;
    logic lit_to_skip;
    logic lit_to_ctrl;
    logic skip_to_ctrl;
    logic beat_last;
  } br1_status_t;

endpackage : br1_pkg
`default_nettype wire

### rtl/core/br1_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// br1_ctrl
// Decode phase state machine: steers control, literal, run and skip bytes
// and sequences the output beats of a run.
// ----------------------------------------------------------------------------
module br1_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_frame_start,
  output logic                      in_stall,
  input  wire br1_pkg::br1_status_t sts,
  output br1_pkg::br1_cmd_t         cmd
);
  import br1_pkg::*;

  br1_state_t state_r, state_nxt;
  br1_state_t phase;
  logic       accept;

  // a new frame forces the control phase
  assign phase    = in_frame_start ? ST_CTRL : state_r;
  assign in_stall = (state_r == ST_EMIT) || !sts.slot_free;
  assign accept   = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (state_r == ST_EMIT) begin
      if (sts.slot_free && sts.beat_last) state_nxt = ST_CTRL;
    end else if (accept) begin
      case (phase)
        ST_CTRL: state_nxt = sts.code_is_run ? ST_RUN : ST_LIT;
        ST_LIT: begin
          if (sts.lit_to_skip)      state_nxt = ST_SKIP;
          else if (sts.lit_to_ctrl) state_nxt = ST_CTRL;
          else                      state_nxt = ST_LIT;
        end
        ST_RUN:  state_nxt = ST_EMIT;
        ST_SKIP: state_nxt = sts.skip_to_ctrl ? ST_CTRL : ST_SKIP;
        default: state_nxt = ST_CTRL;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    if (state_r == ST_EMIT) begin
      cmd.beat = sts.slot_free;
    end else if (accept) begin
      case (phase)
        ST_CTRL: begin
          cmd.load_ctrl = 1'b1;
          cmd.restart   = in_frame_start;
        end
        ST_LIT:  cmd.lit      = 1'b1;
        ST_RUN:  cmd.run_load = 1'b1;
        ST_SKIP: cmd.skip     = 1'b1;
        default: cmd = '0;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CTRL;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : br1_ctrl
`default_nettype wire

### rtl/core/br1_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// br1_datapath
// Position counters, packet byte count, run beat splitter and the output
// register of the byterun1 decoder.
// ----------------------------------------------------------------------------
module br1_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire br1_pkg::br1_cmd_t    cmd,
  output br1_pkg::br1_status_t      sts,
  input  wire logic [2:0]           plane_count,
  input  wire logic [7:0]           in_code_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               out_address,
  output logic [7:0]                out_data0,
  output logic [7:0]                out_data1,
  output logic [7:0]                out_data2,
  output logic [7:0]                out_data3,
  output logic [2:0]                out_valid_bytes,
  output logic                      out_last,
  output logic                      out_body_done,
  output logic                      out_overrun
);
  import br1_pkg::*;

  // state registers
  logic [7:0] pending_r, pending_nxt;
  logic [5:0] column_r, column_nxt;
  logic [2:0] plane_r, plane_nxt;
  logic [7:0] row_r, row_nxt;
  logic [5:0] left_r, left_nxt;
  logic [7:0] run_byte_r, run_byte_nxt;
  logic       run_ovr_r, run_ovr_nxt;

  // output register
  logic        ovld_r, ovld_nxt;
  logic [15:0] oaddr_r, oaddr_nxt;
  logic [7:0]  od0_r, od0_nxt, od1_r, od1_nxt, od2_r, od2_nxt, od3_r, od3_nxt;
  logic [2:0]  onb_r, onb_nxt;
  logic        olast_r, olast_nxt, odone_r, odone_nxt, oovr_r, oovr_nxt;

  logic [2:0]  eff_planes;
  logic [15:0] cur_addr;
  logic [7:0]  pend_dec;
  logic [6:0]  col_lit;
  logic [5:0]  room;
  logic [5:0]  place;
  logic        run_ovr;
  logic [2:0]  beat_n;
  logic [6:0]  col_beat;
  logic [3:0]  plane_inc;
  logic [8:0]  row_inc;
  logic        adv_plane_wrap;
  logic        adv_row_wrap;
  logic [7:0]  ctrl_pending;
  logic        slot_free;
  logic        load_out;

  // effective plane count: zero acts as one, clipped at the maximum
  always_comb begin
    if (plane_count == 3'd0)
      eff_planes = 3'd1;
    else if (plane_count > 3'(MAX_PLANES))
      eff_planes = 3'(MAX_PLANES);
    else
      eff_planes = plane_count;
  end

  // planar screen address of the current position
  assign cur_addr = 16'(plane_r * 16'(PLANE_BYTES)) + 16'(row_r * 14'(ROW_BYTES))
                  + 16'(column_r);

  // row advance terms
  assign plane_inc      = {1'b0, plane_r} + 4'd1;
  assign row_inc        = {1'b0, row_r} + 9'd1;
  assign adv_plane_wrap = plane_inc >= {1'b0, eff_planes};
  assign adv_row_wrap   = row_inc >= 9'(ROWS);

  // packet length from a control byte
  assign ctrl_pending = in_code_byte[7] ? 8'(9'd257 - {1'b0, in_code_byte})
                                        : {1'b0, in_code_byte[6:0]} + 8'd1;

  assign pend_dec = (pending_r != 8'd0) ? pending_r - 8'd1 : 8'd0;
  assign col_lit  = {1'b0, column_r} + 7'd1;

  // run clipped at the row end
  assign room    = 6'(ROW_BYTES) - column_r;
  assign place   = (pending_r < {2'b0, room}) ? pending_r[5:0] : room;
  assign run_ovr = pending_r > {2'b0, room};

  // one beat of a run
  assign beat_n   = (left_r >= 6'(LANES)) ? 3'(LANES) : left_r[2:0];
  assign col_beat = {1'b0, column_r} + {4'b0, beat_n};

  assign slot_free = !ovld_r || !out_stall;
  assign load_out  = cmd.lit || cmd.beat;

  // status to controller
  always_comb begin
    sts.slot_free    = slot_free;
    sts.code_is_run  = in_code_byte[7];
    sts.lit_to_skip  = (col_lit >= 7'(ROW_BYTES)) && (pend_dec != 8'd0);
    sts.lit_to_ctrl  = (pend_dec == 8'd0);
    sts.skip_to_ctrl = (pend_dec == 8'd0);
    sts.beat_last    = (left_r <= 6'(LANES));
  end

  // position, count and run state update
  always_comb begin
    pending_nxt  = pending_r;
    column_nxt   = column_r;
    plane_nxt    = plane_r;
    row_nxt      = row_r;
    left_nxt     = left_r;
    run_byte_nxt = run_byte_r;
    run_ovr_nxt  = run_ovr_r;
    oaddr_nxt    = oaddr_r;
    od0_nxt      = od0_r;
    od1_nxt      = od1_r;
    od2_nxt      = od2_r;
    od3_nxt      = od3_r;
    onb_nxt      = onb_r;
    olast_nxt    = olast_r;
    odone_nxt    = odone_r;
    oovr_nxt     = oovr_r;
    ovld_nxt     = ovld_r && out_stall;

    // control byte, with an optional restart of the body
    if (cmd.load_ctrl) begin
      pending_nxt = ctrl_pending;
      if (cmd.restart) begin
        column_nxt = 6'd0;
        plane_nxt  = 3'd0;
        row_nxt    = 8'd0;
      end
    end

    // literal byte
    if (cmd.lit) begin
      pending_nxt = pend_dec;
      oaddr_nxt   = cur_addr;
      od0_nxt     = in_code_byte;
      od1_nxt     = 8'd0;
      od2_nxt     = 8'd0;
      od3_nxt     = 8'd0;
      onb_nxt     = 3'd1;
      olast_nxt   = 1'b1;
      odone_nxt   = 1'b0;
      oovr_nxt    = 1'b0;
      if (col_lit >= 7'(ROW_BYTES)) begin
        column_nxt = 6'd0;
        oovr_nxt   = (pend_dec != 8'd0);
        if (adv_plane_wrap) begin
          plane_nxt = 3'd0;
          if (adv_row_wrap) begin
            row_nxt   = 8'd0;
            odone_nxt = 1'b1;
          end else begin
            row_nxt = row_inc[7:0];
          end
        end else begin
          plane_nxt = plane_inc[2:0];
        end
      end else begin
        column_nxt = col_lit[5:0];
      end
    end

    // run byte: latch the clipped run
    if (cmd.run_load) begin
      pending_nxt  = 8'd0;
      left_nxt     = place;
      run_byte_nxt = in_code_byte;
      run_ovr_nxt  = run_ovr;
    end

    // dropped literal bytes
    if (cmd.skip) begin
      pending_nxt = pend_dec;
    end

    // one run beat
    if (cmd.beat) begin
      left_nxt  = left_r - {3'b0, beat_n};
      oaddr_nxt = cur_addr;
      od0_nxt   = run_byte_r;
      od1_nxt   = (beat_n > 3'd1) ? run_byte_r : 8'd0;
      od2_nxt   = (beat_n > 3'd2) ? run_byte_r : 8'd0;
      od3_nxt   = (beat_n > 3'd3) ? run_byte_r : 8'd0;
      onb_nxt   = beat_n;
      olast_nxt = sts.beat_last;
      odone_nxt = 1'b0;
      oovr_nxt  = sts.beat_last && run_ovr_r;
      if (sts.beat_last && (col_beat >= 7'(ROW_BYTES))) begin
        column_nxt = 6'd0;
        if (adv_plane_wrap) begin
          plane_nxt = 3'd0;
          if (adv_row_wrap) begin
            row_nxt   = 8'd0;
            odone_nxt = 1'b1;
          end else begin
            row_nxt = row_inc[7:0];
          end
        end else begin
          plane_nxt = plane_inc[2:0];
        end
      end else begin
        column_nxt = col_beat[5:0];
      end
    end

    if (load_out) ovld_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
      column_r  <= 6'd0;
      plane_r   <= 3'd0;
      row_r     <= 8'd0;
      left_r    <= 6'd0;
      ovld_r    <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      column_r  <= column_nxt;
      plane_r   <= plane_nxt;
      row_r     <= row_nxt;
      left_r    <= left_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    run_byte_r <= run_byte_nxt;
    run_ovr_r  <= run_ovr_nxt;
    oaddr_r    <= oaddr_nxt;
    od0_r      <= od0_nxt;
    od1_r      <= od1_nxt;
    od2_r      <= od2_nxt;
    od3_r      <= od3_nxt;
    onb_r      <= onb_nxt;
    olast_r    <= olast_nxt;
    odone_r    <= odone_nxt;
    oovr_r     <= oovr_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_address     = oaddr_r;
  assign out_data0       = od0_r;
  assign out_data1       = od1_r;
  assign out_data2       = od2_r;
  assign out_data3       = od3_r;
  assign out_valid_bytes = onb_r;
  assign out_last        = olast_r;
  assign out_body_done   = odone_r;
  assign out_overrun     = oovr_r;

  // the column never rests at or past the row end
  a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    column_r < 6'(ROW_BYTES))
    else $error("column past row end");

  // a shown transaction carries one to four bytes
  a_lane_count: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (onb_r >= 3'd1 && onb_r <= 3'(LANES)))
    else $error("bad lane count");

  // completion and overrun flags only on the final transaction of a byte
  a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && (odone_r || oovr_r)) |-> olast_r)
    else $error("flag on non-final transaction");

  // a run beat never drives the column beyond the row end
  a_beat_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.beat |-> (col_beat <= 7'(ROW_BYTES)))
    else $error("run beat past row end");

endmodule : br1_datapath
`default_nettype wire

### rtl/core/byterun1_planar_body_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byterun1_planar_body_decoder
// ByteRun1 compressed image body decoder with interleaved bitplane rows and
// planar screen addresses, up to four decoded bytes per output transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | code_byte, frame_start
//  out_    | output    | out_valid / out_stall | address, data0..3, valid_bytes,
//          |           |                       | last, body_done, overrun
//  cfg     | input     | psel/penable/pready   | plane_count, paddr[2] low (0..3)
//
//  control, literal and dropped bytes are each taken as one input transaction
//  a run byte is followed by ceil(n/4) output beats, n being the run clipped
//  at the row end (at most 10 beats), set by the single beat unit
//  input stalls during run beats and while the output register is held
//  synchronous active-low reset; no clearing pass after reset
// ----------------------------------------------------------------------------
module byterun1_planar_body_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_code_byte,
  input  wire logic        in_frame_start,
  // output transactions
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_address,
  output logic [7:0]       out_data0,
  output logic [7:0]       out_data1,
  output logic [7:0]       out_data2,
  output logic [7:0]       out_data3,
  output logic [2:0]       out_valid_bytes,
  output logic             out_last,
  output logic             out_body_done,
  output logic             out_overrun,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import br1_pkg::*;

  br1_cmd_t    cmd;
  br1_status_t sts;
  logic [2:0]  plane_count_r;
  logic        reg_sel;

  // register decode
  assign reg_sel = (paddr[2] == REG_PLANE_COUNT[0]);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {29'd0, plane_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= PLANE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      plane_count_r <= pwdata[2:0];
    end
  end

  br1_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .in_stall       (in_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  br1_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .plane_count     (plane_count_r),
    .in_code_byte    (in_code_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_address     (out_address),
    .out_data0       (out_data0),
    .out_data1       (out_data1),
    .out_data2       (out_data2),
    .out_data3       (out_data3),
    .out_valid_bytes (out_valid_bytes),
    .out_last        (out_last),
    .out_body_done   (out_body_done),
    .out_overrun     (out_overrun)
  );

endmodule : byterun1_planar_body_decoder
`default_nettype wire
